// File: hw/rtl/qrv_pkg.sv
// Shared types and widths for the quaternion vector rotation unit.
// No dependencies; used by the cells and the top level.
package qrv_pkg;

	localparam int unsigned SQRT_W = 63;   // radicand S * 2^30 and partial-root width
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned PROD_W = 52;   // exact vector part of q*a*conj(q)
	localparam int unsigned REM_W = 55;    // 4*|P| + M
	localparam int unsigned QUO_W = 17;    // quotient bits kept below the overflow test
	localparam int unsigned P_DELAY = 30;  // align products with the root
	// request edge to result edge: capture and product stages ahead of the root
	// chain, root chain, divider set-up, divider chain, output register
	localparam int unsigned LAT = 4 + SQRT_STEPS + 1 + QUO_W;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic signed [15:0] vec_z;
	} req_word_t;

	typedef struct packed {
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic               clipped;
		logic               zero_quat;
	} rsp_word_t;

	typedef struct packed {
		logic [SQRT_W-1:0] n;
		logic [SQRT_W-1:0] r;
		logic [SQRT_W-1:0] b;
	} sqrt_state_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] d;
		logic [QUO_W-1:0] quo;
	} div_state_t;

endpackage

// File: hw/rtl/qrv_sqrt_cell.sv
// One digit-recurrence step of the integer square root.
// Depends on qrv_pkg.
module qrv_sqrt_cell (
	input  logic                clk,
	input  qrv_pkg::sqrt_state_t prev,
	output qrv_pkg::sqrt_state_t next_q
);
	import qrv_pkg::*;

	logic [SQRT_W-1:0] trial;
	sqrt_state_t       step;

	always_comb begin
		trial = prev.r + prev.b;
		step.b = prev.b >> 2;
		if (prev.n >= trial) begin
			step.n = prev.n - trial;
			step.r = (prev.r >> 1) + prev.b;
		end else begin
			step.n = prev.n;
			step.r = prev.r >> 1;
		end
	end

	// advance one root bit per cycle
	always_ff @(posedge clk) begin
		next_q <= step;
	end
endmodule

// File: hw/rtl/qrv_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on qrv_pkg.
module qrv_div_cell (
	input  logic               clk,
	input  qrv_pkg::div_state_t prev,
	output qrv_pkg::div_state_t next_q
);
	import qrv_pkg::*;

	div_state_t step;

	always_comb begin
		step.d = prev.d >> 1;
		if (prev.rem >= prev.d) begin
			step.rem = prev.rem - prev.d;
			step.quo = {prev.quo[QUO_W-2:0], 1'b1};
		end else begin
			step.rem = prev.rem;
			step.quo = {prev.quo[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		next_q <= step;
	end
endmodule

// File: hw/rtl/quaternion_rotate_vector_unit.sv
// Top level of the quaternion vector rotation unit: product pipeline,
// square-root cell chain and three divider cell chains. Depends on qrv_pkg,
// qrv_sqrt_cell and qrv_div_cell.

// Every word raised with start is taken at once: busy is tied low and a new
// word may enter on every clock. The result word is driven on rsp_word with done
// high for exactly one cycle; the receiver cannot stall it, so it must sample
// whenever done is high.
// Latency is set by the 32-cell square-root chain (one root bit per cell)
// followed by the 17-cell divider chains (one quotient bit per cell), plus
// the multiply stages ahead, the divider set-up stage and the final saturation
// stage. Results leave in request order. A zero quaternion gives zero
// components with zero_quat set; components beyond Q8.7 saturate and set clipped.
module quaternion_rotate_vector_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  qrv_pkg::req_word_t req_word,
	output logic               done,
	output qrv_pkg::rsp_word_t rsp_word
);
	import qrv_pkg::*;

	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][PROD_W-1:0] mag;
		logic                   zero;
	} prod_tag_t;

	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] ovf;
		logic       zero;
	} div_tag_t;

	// valid chain: the only state that reset clears
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	// stage 1: capture the request word
	req_word_t in_s1;
	always_ff @(posedge clk) begin
		in_s1 <= req_word;
	end

	// stage 2: squares for |q|^2 and the products of a * conj(q)
	logic signed [31:0] sq_s2 [4];
	logic signed [31:0] tp_s2 [12];
	logic signed [15:0] qw_s2, qx_s2, qy_s2, qz_s2;

	always_ff @(posedge clk) begin
		sq_s2[0] <= in_s1.quat_w * in_s1.quat_w;
		sq_s2[1] <= in_s1.quat_x * in_s1.quat_x;
		sq_s2[2] <= in_s1.quat_y * in_s1.quat_y;
		sq_s2[3] <= in_s1.quat_z * in_s1.quat_z;
		tp_s2[0]  <= in_s1.vec_x * in_s1.quat_x;
		tp_s2[1]  <= in_s1.vec_y * in_s1.quat_y;
		tp_s2[2]  <= in_s1.vec_z * in_s1.quat_z;
		tp_s2[3]  <= in_s1.vec_x * in_s1.quat_w;
		tp_s2[4]  <= in_s1.vec_y * in_s1.quat_z;
		tp_s2[5]  <= in_s1.vec_z * in_s1.quat_y;
		tp_s2[6]  <= in_s1.vec_y * in_s1.quat_w;
		tp_s2[7]  <= in_s1.vec_z * in_s1.quat_x;
		tp_s2[8]  <= in_s1.vec_x * in_s1.quat_z;
		tp_s2[9]  <= in_s1.vec_z * in_s1.quat_w;
		tp_s2[10] <= in_s1.vec_x * in_s1.quat_y;
		tp_s2[11] <= in_s1.vec_y * in_s1.quat_x;
		qw_s2 <= in_s1.quat_w;
		qx_s2 <= in_s1.quat_x;
		qy_s2 <= in_s1.quat_y;
		qz_s2 <= in_s1.quat_z;
	end

	// stage 3: |q|^2 and t = a * conj(q), vector quaternion has w = 0
	logic [32:0]        s_s3;
	logic signed [33:0] t_s3 [4];
	logic signed [15:0] qw_s3, qx_s3, qy_s3, qz_s3;

	always_ff @(posedge clk) begin
		s_s3 <= 33'(sq_s2[0]) + 33'(sq_s2[1]) + 33'(sq_s2[2]) + 33'(sq_s2[3]);
		t_s3[0] <= 34'(tp_s2[0]) + 34'(tp_s2[1]) + 34'(tp_s2[2]);
		t_s3[1] <= 34'(tp_s2[3]) - 34'(tp_s2[4]) + 34'(tp_s2[5]);
		t_s3[2] <= 34'(tp_s2[6]) - 34'(tp_s2[7]) + 34'(tp_s2[8]);
		t_s3[3] <= 34'(tp_s2[9]) - 34'(tp_s2[10]) + 34'(tp_s2[11]);
		qw_s3 <= qw_s2;
		qx_s3 <= qx_s2;
		qy_s3 <= qy_s2;
		qz_s3 <= qz_s2;
	end

	// stage 4: products of q * t for the vector part
	logic signed [49:0] pp_s4 [12];
	logic               zero_s4;

	always_ff @(posedge clk) begin
		pp_s4[0]  <= qw_s3 * t_s3[1];
		pp_s4[1]  <= qx_s3 * t_s3[0];
		pp_s4[2]  <= qy_s3 * t_s3[3];
		pp_s4[3]  <= qz_s3 * t_s3[2];
		pp_s4[4]  <= qw_s3 * t_s3[2];
		pp_s4[5]  <= qy_s3 * t_s3[0];
		pp_s4[6]  <= qz_s3 * t_s3[1];
		pp_s4[7]  <= qx_s3 * t_s3[3];
		pp_s4[8]  <= qw_s3 * t_s3[3];
		pp_s4[9]  <= qz_s3 * t_s3[0];
		pp_s4[10] <= qx_s3 * t_s3[2];
		pp_s4[11] <= qy_s3 * t_s3[1];
		zero_s4 <= (s_s3 == '0);
	end

	// stage 5: sum each lane, split into sign and magnitude
	logic signed [PROD_W-1:0] psum [3];
	prod_tag_t                ptag_s5;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			psum[k] = PROD_W'(pp_s4[4*k]) + PROD_W'(pp_s4[4*k+1])
			        + PROD_W'(pp_s4[4*k+2]) - PROD_W'(pp_s4[4*k+3]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ptag_s5.neg[k] <= psum[k][PROD_W-1];
			ptag_s5.mag[k] <= psum[k][PROD_W-1] ? PROD_W'(-psum[k]) : PROD_W'(psum[k]);
		end
		ptag_s5.zero <= zero_s4;
	end

	// hold the products until the root leaves its chain
	prod_tag_t ptag_q [P_DELAY];
	always_ff @(posedge clk) begin
		ptag_q[0] <= ptag_s5;
		for (int k = 1; k < P_DELAY; k++) begin
			ptag_q[k] <= ptag_q[k-1];
		end
	end

	// square-root chain on S * 2^30, one root bit per cell
	sqrt_state_t sq_chain [SQRT_STEPS+1];
	assign sq_chain[0].n = {s_s3, 30'd0};
	assign sq_chain[0].r = '0;
	assign sq_chain[0].b = SQRT_W'(1) << (SQRT_W - 1);

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		qrv_sqrt_cell u_cell (
			.clk    (clk),
			.prev   (sq_chain[g]),
			.next_q (sq_chain[g+1])
		);
	end

	// divider set-up: N = 4|P| + M, D = 2M, and the overflow test N >= D * 2^17
	logic [31:0]      root;
	logic [REM_W-1:0] num   [3];
	logic [REM_W-1:0] den;
	logic [REM_W-1:0] den_top;
	div_state_t       dv_s36 [3];
	div_tag_t         dtag_s36;

	assign root    = sq_chain[SQRT_STEPS].r[31:0];
	assign den     = REM_W'({root, 1'b0});
	assign den_top = den << QUO_W;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = REM_W'({ptag_q[P_DELAY-1].mag[k], 2'b00}) + REM_W'(root);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dv_s36[k].rem <= num[k];
			dv_s36[k].d   <= den << (QUO_W - 1);
			dv_s36[k].quo <= '0;
			dtag_s36.ovf[k] <= (num[k] >= den_top);
		end
		dtag_s36.neg  <= ptag_q[P_DELAY-1].neg;
		dtag_s36.zero <= ptag_q[P_DELAY-1].zero;
	end

	// three divider chains, one quotient bit per cell
	div_state_t dv_chain [3][QUO_W+1];
	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign dv_chain[l][0] = dv_s36[l];
		for (genvar g = 0; g < QUO_W; g++) begin : g_div
			qrv_div_cell u_cell (
				.clk    (clk),
				.prev   (dv_chain[l][g]),
				.next_q (dv_chain[l][g+1])
			);
		end
	end

	div_tag_t dtag_q [QUO_W];
	always_ff @(posedge clk) begin
		dtag_q[0] <= dtag_s36;
		for (int k = 1; k < QUO_W; k++) begin
			dtag_q[k] <= dtag_q[k-1];
		end
	end

	// final stage: saturate, apply sign, drop everything on a zero quaternion
	logic [QUO_W-1:0]   quo [3];
	logic signed [15:0] lane_val [3];
	logic [2:0]         lane_clip;
	div_tag_t           dtag_end;
	rsp_word_t          rsp_d;

	assign dtag_end = dtag_q[QUO_W-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			quo[k] = dv_chain[k][QUO_W].quo;
			if (dtag_end.neg[k]) begin
				lane_clip[k] = dtag_end.ovf[k] || (quo[k] > QUO_W'(32768));
				lane_val[k]  = lane_clip[k] ? 16'sh8000 : 16'(-quo[k]);
			end else begin
				lane_clip[k] = dtag_end.ovf[k] || (quo[k] > QUO_W'(32767));
				lane_val[k]  = lane_clip[k] ? 16'sh7fff : 16'(quo[k]);
			end
		end
		if (dtag_end.zero) begin
			rsp_d.rot_x     = '0;
			rsp_d.rot_y     = '0;
			rsp_d.rot_z     = '0;
			rsp_d.clipped   = 1'b0;
			rsp_d.zero_quat = 1'b1;
		end else begin
			rsp_d.rot_x     = lane_val[0];
			rsp_d.rot_y     = lane_val[1];
			rsp_d.rot_z     = lane_val[2];
			rsp_d.clipped   = |lane_clip;
			rsp_d.zero_quat = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rsp_word <= rsp_d;
	end
endmodule
